[rtl/core/jsmc_pkg.sv]
`timescale 1ns / 1ps

package jsmc_pkg;

	// Axis count and key mask width
	localparam int AXES  = 6;
	localparam int KEY_W = 6;
	localparam logic [KEY_W-1:0] AXIS_MASK = KEY_W'((1 << AXES) - 1);

	localparam int AGE_W = 16;
	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_EN = 1'd1;

	localparam logic [AGE_W-1:0] TIMEOUT_RST = 16'd50;

	typedef enum logic [2:0] {
		OP_JOG_CMD    = 3'd0,
		OP_TICK       = 3'd1,
		OP_JOG_FAULT  = 3'd2,
		OP_TRAJ_FAULT = 3'd3,
		OP_ENTER      = 3'd4,
		OP_EXIT       = 3'd5,
		OP_RESET      = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_IDLE   = 2'd1,
		MODE_ACTIVE = 2'd2,
		MODE_FAULT  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		REJ_OK          = 4'd0,
		REJ_WRONG_MODE  = 4'd1,
		REJ_RESET_FIRST = 4'd2,
		REJ_TRAJ_FAULT  = 4'd3,
		REJ_NO_RELEASE  = 4'd4,
		REJ_SUPERVISOR  = 4'd5,
		REJ_SWITCH      = 4'd6,
		REJ_TRAJ_RESET  = 4'd7,
		REJ_CTRL_RESET  = 4'd8
	} reject_t;

	// One input transaction
	typedef struct packed {
		logic [2:0]       operation;
		logic [KEY_W-1:0] key_mask;
		logic             deadman_held;
		logic             fault_cleared;
		logic             supervisor_ok;
		logic             switch_ok;
		logic             trajectory_reset_ok;
		logic             controller_reset_ok;
	} req_t;

	// One result transaction
	typedef struct packed {
		mode_t   mode_now;
		logic    request_success;
		reject_t reject_code;
		logic    hold_strobe;
	} rsp_t;

	// Controller state
	typedef struct packed {
		mode_t            ctrl_mode;
		logic [AGE_W-1:0] command_age;
		logic             command_seen;
		logic             keys_released;
		logic             hold_pending;
		logic             trajectory_fault_pending;
	} state_t;

	// Configuration
	typedef struct packed {
		logic [AGE_W-1:0] timeout;
		logic             hold_en;
	} cfg_t;

endpackage

[rtl/core/jsmc_intf.sv]
`timescale 1ns / 1ps

// Input channel
interface jsmc_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [5:0] key_mask;
	logic       deadman_held;
	logic       fault_cleared;
	logic       supervisor_ok;
	logic       switch_ok;
	logic       trajectory_reset_ok;
	logic       controller_reset_ok;

	modport source (
		output valid, operation, key_mask, deadman_held, fault_cleared,
			supervisor_ok, switch_ok, trajectory_reset_ok, controller_reset_ok,
		input  ready
	);
	modport sink (
		input  valid, operation, key_mask, deadman_held, fault_cleared,
			supervisor_ok, switch_ok, trajectory_reset_ok, controller_reset_ok,
		output ready
	);
endinterface

// Result channel
interface jsmc_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode_now;
	logic       request_success;
	logic [3:0] reject_code;
	logic       hold_strobe;

	modport source (
		output valid, mode_now, request_success, reject_code, hold_strobe,
		input  ready
	);
	modport sink (
		input  valid, mode_now, request_success, reject_code, hold_strobe,
		output ready
	);
endinterface

[rtl/core/jsmc_step.sv]
`timescale 1ns / 1ps

// Next-state and result logic for one transaction
module jsmc_step (
	input  jsmc_pkg::state_t cur,
	input  jsmc_pkg::cfg_t   cfg,
	input  jsmc_pkg::req_t   req,
	output jsmc_pkg::state_t nxt,
	output jsmc_pkg::rsp_t   rsp
);
	import jsmc_pkg::*;

	logic             in_jog;
	logic             fault_ok;
	logic             fresh;
	logic             keys_active;
	logic [AGE_W-1:0] age_inc;

	assign in_jog      = (cur.ctrl_mode == MODE_IDLE) || (cur.ctrl_mode == MODE_ACTIVE);
	assign fault_ok    = in_jog && !cur.hold_pending;
	assign fresh       = cur.command_seen && cur.keys_released && (cur.command_age <= cfg.timeout);
	assign keys_active = |(req.key_mask & AXIS_MASK);
	assign age_inc     = (cur.command_age == AGE_MAX) ? AGE_MAX : cur.command_age + 1'b1;

	always_comb begin
		nxt                 = cur;
		rsp.request_success = 1'b0;
		rsp.reject_code     = REJ_OK;
		rsp.hold_strobe     = 1'b0;

		unique case (op_t'(req.operation))
			OP_JOG_CMD: begin
				nxt.command_seen  = 1'b1;
				nxt.command_age   = '0;
				nxt.keys_released = req.deadman_held && !keys_active;
				if (in_jog) begin
					if (!req.deadman_held) begin
						if (fault_ok) begin
							nxt.hold_pending = 1'b1;
							nxt.ctrl_mode    = MODE_FAULT;
							rsp.hold_strobe  = cfg.hold_en;
						end
					end else begin
						nxt.ctrl_mode = keys_active ? MODE_ACTIVE : MODE_IDLE;
					end
				end
			end
			OP_TICK: begin
				nxt.command_age = age_inc;
				// stale or missing command faults a jog mode
				if (fault_ok && (!cur.command_seen || age_inc > cfg.timeout)) begin
					nxt.hold_pending = 1'b1;
					nxt.ctrl_mode    = MODE_FAULT;
					rsp.hold_strobe  = cfg.hold_en;
				end
			end
			OP_JOG_FAULT: begin
				if (fault_ok) begin
					nxt.hold_pending = 1'b1;
					nxt.ctrl_mode    = MODE_FAULT;
					rsp.hold_strobe  = cfg.hold_en;
				end
			end
			OP_TRAJ_FAULT: begin
				if (req.fault_cleared) begin
					nxt.trajectory_fault_pending = 1'b0;
				end else begin
					nxt.trajectory_fault_pending = 1'b1;
					if (fault_ok) begin
						nxt.hold_pending = 1'b1;
						nxt.ctrl_mode    = MODE_FAULT;
						rsp.hold_strobe  = cfg.hold_en;
					end
				end
			end
			OP_ENTER: begin
				priority if (cur.ctrl_mode != MODE_NORMAL) begin
					rsp.reject_code = REJ_WRONG_MODE;
				end else if (cur.trajectory_fault_pending) begin
					rsp.reject_code = REJ_TRAJ_FAULT;
				end else if (!fresh) begin
					rsp.reject_code = REJ_NO_RELEASE;
				end else if (!req.supervisor_ok) begin
					rsp.reject_code = REJ_SUPERVISOR;
				end else if (!req.switch_ok) begin
					rsp.reject_code = REJ_SWITCH;
					nxt.ctrl_mode   = MODE_FAULT;
				end else begin
					nxt.hold_pending    = 1'b0;
					nxt.ctrl_mode       = MODE_IDLE;
					rsp.request_success = 1'b1;
				end
			end
			OP_EXIT: begin
				priority if (cur.ctrl_mode == MODE_FAULT) begin
					rsp.reject_code = REJ_RESET_FIRST;
				end else if (cur.ctrl_mode != MODE_IDLE) begin
					rsp.reject_code = REJ_WRONG_MODE;
				end else if (!req.supervisor_ok) begin
					rsp.reject_code = REJ_SUPERVISOR;
				end else if (!req.switch_ok) begin
					rsp.reject_code = REJ_SWITCH;
					nxt.ctrl_mode   = MODE_FAULT;
				end else begin
					nxt.ctrl_mode       = MODE_NORMAL;
					rsp.request_success = 1'b1;
				end
			end
			OP_RESET: begin
				priority if (cur.ctrl_mode != MODE_FAULT) begin
					rsp.reject_code = REJ_WRONG_MODE;
				end else if (!fresh) begin
					rsp.reject_code = REJ_NO_RELEASE;
				end else if (cfg.hold_en && !req.trajectory_reset_ok) begin
					rsp.reject_code = REJ_TRAJ_RESET;
				end else if (!req.controller_reset_ok) begin
					rsp.reject_code = REJ_CTRL_RESET;
				end else begin
					nxt.trajectory_fault_pending = 1'b0;
					nxt.hold_pending             = 1'b0;
					nxt.ctrl_mode                = MODE_IDLE;
					rsp.request_success          = 1'b1;
				end
			end
			default: begin
				// unused operation code: no change
			end
		endcase

		rsp.mode_now = nxt.ctrl_mode;
	end

endmodule

[rtl/core/jog_safety_mode_controller_core.sv]
`timescale 1ns / 1ps

// Jog safety mode controller.
// req: one transaction per operation (jog command, tick, jog fault, trajectory
//   fault report, enter, exit, reset) with its partner answers; taken when
//   valid and ready are both high.
// rsp: exactly one result transaction per request: mode after the operation,
//   request success, reject code and hold strobe.
// cfg: write port, cfg_index 0 is the command timeout in ticks, 1 enables
//   hold on fault; write only while no transaction is in flight.
// Path: a taken request is registered in the input stage, evaluated against the
//   controller state and shown on rsp from the result register (two register stages).
// Throughput: one transaction per cycle while rsp.ready holds, set by the single
//   evaluation stage, which updates the state at the same edge that loads the result register.
// Reset: mode normal, all flags and the command age clear, timeout 50, hold
//   enabled; both stages empty.
// Stall: a held result stays in the output register; the input stage still
//   takes one more transaction, and req.ready drops only while both are full.
module jog_safety_mode_controller_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [jsmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [jsmc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	jsmc_req_if.sink                           req,
	jsmc_rsp_if.source                         rsp
);
	import jsmc_pkg::*;

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_nxt;
	req_t   req_s1;
	logic   valid_s1;
	rsp_t   rsp_s2;
	rsp_t   rsp_nxt;
	logic   valid_s2;
	logic   advance;

	// Stage 1 moves on when the result register is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout <= TIMEOUT_RST;
			cfg_q.hold_en <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMEOUT: cfg_q.timeout <= cfg_wdata[AGE_W-1:0];
				CFG_HOLD_EN: cfg_q.hold_en <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.operation           <= req.operation;
			req_s1.key_mask            <= req.key_mask;
			req_s1.deadman_held        <= req.deadman_held;
			req_s1.fault_cleared       <= req.fault_cleared;
			req_s1.supervisor_ok       <= req.supervisor_ok;
			req_s1.switch_ok           <= req.switch_ok;
			req_s1.trajectory_reset_ok <= req.trajectory_reset_ok;
			req_s1.controller_reset_ok <= req.controller_reset_ok;
		end
	end

	jsmc_step u_step (
		.cur (state_q),
		.cfg (cfg_q),
		.req (req_s1),
		.nxt (state_nxt),
		.rsp (rsp_nxt)
	);

	// Controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.ctrl_mode                <= MODE_NORMAL;
			state_q.command_age              <= '0;
			state_q.command_seen             <= 1'b0;
			state_q.keys_released            <= 1'b0;
			state_q.hold_pending             <= 1'b0;
			state_q.trajectory_fault_pending <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_nxt;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.mode_now        = rsp_s2.mode_now;
	assign rsp.request_success = rsp_s2.request_success;
	assign rsp.reject_code     = rsp_s2.reject_code;
	assign rsp.hold_strobe     = rsp_s2.hold_strobe;

endmodule
